[rtl/sspd_pkg.sv]
// shared types, constants and codes of the sweep sync pulse decoder
package sspd_pkg;

  localparam int unsigned TsBits      = 32;
  localparam int unsigned BiasBits    = 10;
  localparam int unsigned MaxBits     = 16;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned BndBits     = 11;
  localparam int unsigned ThrBits     = 12;
  localparam int unsigned NumBounds   = 10;
  localparam int unsigned NumAxes     = 2;
  localparam int unsigned NumStations = 2;
  localparam int unsigned QDepth      = 2;

  typedef logic [TsBits-1:0]   ts_t;
  typedef logic [BndBits-1:0]  bnd_t;
  typedef logic [ThrBits-1:0]  thr_t;

  localparam logic [CfgIdxBits-1:0] CfgWidthBias = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgMaxDelta  = 1'd1;

  localparam logic [BiasBits-1:0] WidthBiasRst = '0;
  localparam logic [MaxBits-1:0]  MaxDeltaRst  = 16'd4630;

  // width bin edges in ticks, each shifted by the bias
  localparam bnd_t Bounds [NumBounds] = '{
    11'd100, 11'd585, 11'd675, 11'd781, 11'd885,
    11'd989, 11'd1083, 11'd1200, 11'd1300, 11'd1400
  };

  localparam logic StationA = 1'b0;
  localparam logic StationB = 1'b1;

  typedef enum logic [1:0] {
    KindLaser,
    KindSync,
    KindSkip
  } kind_e;

  typedef enum logic [2:0] {
    PhSearch,
    PhSyncA,
    PhSkipB,
    PhWaitA,
    PhWaitB
  } phase_e;

  typedef struct packed {
    kind_e kind;
    logic  axis;
    ts_t   rise;
  } pulse_t;

  typedef struct packed {
    logic hit;
    logic station;
    ts_t  sync;
    ts_t  laser;
    ts_t  delta;
    ts_t  prev;
  } cand_t;

endpackage

[rtl/sspd_if.sv]
// handshake interfaces for pulse words in and sweep words out
interface sspd_pulse_if ();
  import sspd_pkg::*;

  logic valid;
  logic ready;
  ts_t  rise_time;
  ts_t  fall_time;

  modport source (output valid, rise_time, fall_time, input ready);
  modport sink   (input valid, rise_time, fall_time, output ready);
endinterface

interface sspd_sweep_if ();
  import sspd_pkg::*;

  logic valid;
  logic ready;
  ts_t  sync_ts;
  ts_t  laser_ts;
  logic station;
  logic axis;

  modport source (output valid, sync_ts, laser_ts, station, axis, input ready);
  modport sink   (input valid, sync_ts, laser_ts, station, axis, output ready);
endinterface

[rtl/sspd_front.sv]
// front end: takes pulse words, classifies the width and drops invalid pulses
module sspd_front (
  sspd_pulse_if.sink                      pulse_i,
  input  logic [sspd_pkg::BiasBits-1:0]   width_bias_i,
  input  logic                            full_i,
  output logic                            push_o,
  output sspd_pkg::pulse_t                pulse_o
);
  import sspd_pkg::*;

  ts_t    width;
  thr_t   thr [NumBounds];
  logic   ge  [NumBounds];
  logic   gt_lo;
  logic   gt_sync;
  logic   known;
  kind_e  kind;
  logic   axis;

  always_comb begin
    width = pulse_i.fall_time - pulse_i.rise_time;
    for (int k = 0; k < NumBounds; k++) begin
      thr[k] = ThrBits'(Bounds[k]) + ThrBits'(width_bias_i);
      ge[k]  = width >= TsBits'(thr[k]);
    end
    gt_lo   = ge[0] && (width != TsBits'(thr[0]));
    gt_sync = ge[1] && (width != TsBits'(thr[1]));

    known = 1'b1;
    kind  = KindLaser;
    axis  = 1'b0;
    if (gt_lo && !ge[1]) begin
      kind = KindLaser;
    end else if (gt_sync && !ge[2]) begin
      kind = KindSync;
    end else if (ge[2] && !ge[3]) begin
      kind = KindSync;
      axis = 1'b1;
    end else if (ge[3] && !ge[4]) begin
      kind = KindSync;
    end else if (ge[4] && !ge[5]) begin
      kind = KindSync;
      axis = 1'b1;
    end else if (ge[5] && !ge[6]) begin
      kind = KindSkip;
    end else if (ge[6] && !ge[7]) begin
      kind = KindSkip;
      axis = 1'b1;
    end else if (ge[7] && !ge[8]) begin
      kind = KindSkip;
    end else if (ge[8] && !ge[9]) begin
      kind = KindSkip;
      axis = 1'b1;
    end else begin
      known = 1'b0;
    end
  end

  assign pulse_i.ready = !full_i;
  assign push_o        = pulse_i.valid && !full_i && known;
  assign pulse_o       = '{kind: kind, axis: axis, rise: pulse_i.rise_time};

endmodule

[rtl/sspd_queue.sv]
// short queue of classified pulses between front and back
module sspd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sspd_pkg::pulse_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output sspd_pkg::pulse_t  rdata_o,
  output logic              empty_o
);
  import sspd_pkg::*;

  localparam int unsigned PtrBits = $clog2(QDepth);
  localparam int unsigned CntBits = $clog2(QDepth + 1);

  pulse_t               mem_q [QDepth];
  logic [PtrBits-1:0]   wr_ptr_q;
  logic [PtrBits-1:0]   rd_ptr_q;
  logic [CntBits-1:0]   cnt_q;
  logic [CntBits-1:0]   cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntBits'(1);
      2'b01:   cnt_d = cnt_q - CntBits'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == CntBits'(QDepth);
  assign empty_o = cnt_q == '0;

endmodule

[rtl/sspd_back.sv]
// back end: azimuth and elevation trackers, sync stamps and previous deltas
module sspd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sspd_pkg::pulse_t  pulse_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic              adv_i,
  output logic              cand_valid_o,
  output sspd_pkg::cand_t   cand_o [sspd_pkg::NumAxes]
);
  import sspd_pkg::*;

  phase_e phase_q [NumAxes];
  phase_e phase_d [NumAxes];
  ts_t    stamp_q [NumAxes][NumStations];
  ts_t    stamp_d [NumAxes][NumStations];
  ts_t    prev_q  [NumAxes][NumStations];
  ts_t    prev_d  [NumAxes][NumStations];
  cand_t  cand_q  [NumAxes];
  cand_t  cand_d  [NumAxes];
  logic   cand_valid_q;
  logic   cand_valid_d;
  logic   load;
  logic   mine_sync;
  logic   mine_skip;
  logic   st;
  ts_t    delta;

  always_comb begin
    load         = !cand_valid_q || adv_i;
    pop_o        = !empty_i && load;
    phase_d      = phase_q;
    stamp_d      = stamp_q;
    prev_d       = prev_q;
    cand_d       = cand_q;
    cand_valid_d = cand_valid_q;
    mine_sync    = 1'b0;
    mine_skip    = 1'b0;
    st           = StationA;
    delta        = '0;
    if (load) begin
      cand_valid_d = 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        cand_d[a].hit = 1'b0;
      end
    end
    if (pop_o) begin
      for (int a = 0; a < NumAxes; a++) begin
        mine_sync = pulse_i.kind == KindSync && pulse_i.axis == 1'(a);
        mine_skip = pulse_i.kind == KindSkip && pulse_i.axis == 1'(a);
        st        = (phase_q[a] == PhWaitB) ? StationB : StationA;
        delta     = pulse_i.rise - stamp_q[a][st];
        unique case (phase_q[a]) inside
          PhSearch, PhSyncA, PhWaitA, PhWaitB: begin
            if (mine_sync) begin
              stamp_d[a][StationA] = pulse_i.rise;
              phase_d[a]           = PhSyncA;
            end else if (mine_skip) begin
              phase_d[a] = (phase_q[a] == PhSyncA) ? PhWaitA : PhSkipB;
            end else if (pulse_i.kind == KindLaser &&
                         (phase_q[a] == PhWaitA || phase_q[a] == PhWaitB)) begin
              cand_d[a]     = '{hit: prev_q[a][st] != '0, station: st,
                                sync: stamp_q[a][st], laser: pulse_i.rise,
                                delta: delta, prev: prev_q[a][st]};
              cand_valid_d  = cand_valid_d || (prev_q[a][st] != '0);
              prev_d[a][st] = delta;
              phase_d[a]    = PhSearch;
            end else begin
              phase_d[a] = PhSearch;
            end
          end
          PhSkipB: begin
            if (mine_sync) begin
              stamp_d[a][StationB] = pulse_i.rise;
              phase_d[a]           = PhWaitB;
            end else if (mine_skip) begin
              phase_d[a] = PhSkipB;
            end else begin
              phase_d[a] = PhSearch;
            end
          end
          default: phase_d[a] = PhSearch;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NumAxes; a++) begin
        phase_q[a] <= PhSearch;
      end
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
      for (int a = 0; a < NumAxes; a++) begin
        for (int s = 0; s < NumStations; s++) begin
          stamp_q[a][s] <= '0;
          prev_q[a][s]  <= '0;
        end
      end
    end else begin
      cand_valid_q <= cand_valid_d;
      stamp_q      <= stamp_d;
      prev_q       <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_o       = cand_q;

endmodule

[rtl/sspd_gap.sv]
// delta change check and output register
module sspd_gap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cand_valid_i,
  input  sspd_pkg::cand_t                cand_i [sspd_pkg::NumAxes],
  input  logic [sspd_pkg::MaxBits-1:0]   max_delta_i,
  output logic                           adv_o,
  sspd_sweep_if.source                   sweep_o
);
  import sspd_pkg::*;

  localparam int unsigned DiffBits = TsBits + 1;

  logic signed [DiffBits-1:0] diff [NumAxes];
  logic signed [DiffBits-1:0] lim;
  logic                       pass [NumAxes];
  logic                       sel;
  logic                       valid_q;
  ts_t                        sync_q;
  ts_t                        laser_q;
  logic                       station_q;
  logic                       axis_q;

  always_comb begin
    lim = $signed({{(DiffBits - MaxBits){1'b0}}, max_delta_i});
    for (int a = 0; a < NumAxes; a++) begin
      diff[a] = $signed({cand_i[a].delta[TsBits-1], cand_i[a].delta})
              - $signed({cand_i[a].prev[TsBits-1], cand_i[a].prev});
      pass[a] = cand_i[a].hit && (diff[a] < lim) && (diff[a] > -lim);
    end
    sel = !pass[0];
  end

  assign adv_o = !valid_q || sweep_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= cand_valid_i && (pass[0] || pass[1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      sync_q    <= cand_i[sel].sync;
      laser_q   <= cand_i[sel].laser;
      station_q <= cand_i[sel].station;
      axis_q    <= sel;
    end
  end

  assign sweep_o.valid    = valid_q;
  assign sweep_o.sync_ts  = sync_q;
  assign sweep_o.laser_ts = laser_q;
  assign sweep_o.station  = station_q;
  assign sweep_o.axis     = axis_q;

endmodule

[rtl/sweep_sync_pulse_decoder_unit.sv]
// top level of the sweep sync pulse decoder
// a pulse word passes through the queue, the candidate register and the output register
// throughput: one pulse word per cycle unless the sweep output stalls; a two-word queue
//   sits between the classifier and the trackers, and the output register lets both run on
// reset: trackers to search, sync stamps and previous deltas to zero,
//   queue and output emptied, width bias to 0 and delta limit to 4630
module sweep_sync_pulse_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sspd_pulse_if.sink                         pulse_i,
  sspd_sweep_if.source                       sweep_o,
  input  logic                               cfg_we_i,
  input  logic [sspd_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [sspd_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import sspd_pkg::*;

  logic [BiasBits-1:0] width_bias_q;
  logic [MaxBits-1:0]  max_delta_q;
  logic                push;
  pulse_t              push_data;
  logic                full;
  logic                pop;
  pulse_t              pop_data;
  logic                empty;
  logic                adv;
  logic                cand_valid;
  cand_t               cand [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_bias_q <= WidthBiasRst;
      max_delta_q  <= MaxDeltaRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidthBias: width_bias_q <= cfg_data_i[BiasBits-1:0];
        CfgMaxDelta:  max_delta_q  <= cfg_data_i[MaxBits-1:0];
        default: ;
      endcase
    end
  end

  sspd_front u_front (
    .pulse_i      (pulse_i),
    .width_bias_i (width_bias_q),
    .full_i       (full),
    .push_o       (push),
    .pulse_o      (push_data)
  );

  sspd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_data),
    .empty_o (empty)
  );

  sspd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pulse_i      (pop_data),
    .empty_i      (empty),
    .pop_o        (pop),
    .adv_i        (adv),
    .cand_valid_o (cand_valid),
    .cand_o       (cand)
  );

  sspd_gap u_gap (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_valid),
    .cand_i       (cand),
    .max_delta_i  (max_delta_q),
    .adv_o        (adv),
    .sweep_o      (sweep_o)
  );

endmodule

[rtl/sspd_check.sv]
// port checker for the sweep sync pulse decoder and its bind
module sspd_check (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input sspd_pkg::ts_t         sync_ts_i,
  input sspd_pkg::ts_t         laser_ts_i,
  input logic                  station_i,
  input logic                  axis_i
);
  import sspd_pkg::*;

  logic stall;

  assign stall = out_valid_i && !out_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> out_valid_i)
    else $error("sweep word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(sync_ts_i) && $stable(laser_ts_i) &&
              $stable(station_i) && $stable(axis_i))
    else $error("sweep word changed while stalled");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("pulse input blocked with no sweep word pending");

  a_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(stall))
    else $error("pulse input blocked without an output stall");

endmodule

bind sweep_sync_pulse_decoder_unit sspd_check u_sspd_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pulse_i.ready),
  .out_valid_i  (sweep_o.valid),
  .out_ready_i  (sweep_o.ready),
  .sync_ts_i    (sweep_o.sync_ts),
  .laser_ts_i   (sweep_o.laser_ts),
  .station_i    (sweep_o.station),
  .axis_i       (sweep_o.axis)
);

[dv/tb_top.sv]
// testbench for the sweep sync pulse decoder: directed and random pulse streams checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import sspd_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TimeoutCycles = 300_000;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 400;

  localparam logic AxisAz = 1'b0;
  localparam logic AxisEl = 1'b1;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHeavy
  } rx_stall_e;

  typedef enum logic [1:0] {
    FormA,
    FormB,
    FormBLong,
    FormQuirk
  } sweep_form_e;

  typedef struct packed {
    ts_t rise;
    ts_t fall;
  } pulse_word_t;

  typedef struct packed {
    ts_t  sync_ts;
    ts_t  laser_ts;
    logic station;
    logic axis;
  } sweep_word_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  sspd_pulse_if pulse_if ();
  sspd_sweep_if sweep_if ();

  sweep_sync_pulse_decoder_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pulse_i    (pulse_if),
    .sweep_o    (sweep_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [BiasBits-1:0] cfg_bias;
  logic [MaxBits-1:0]  cfg_maxd;
  phase_e              trk_phase [NumAxes];
  ts_t                 sync_st [4];
  ts_t                 prev_d [4];

  pulse_word_t pulses_pending [$];
  sweep_word_t sweeps_due [$];
  int unsigned mismatches;

  // stimulus state
  ts_t         t_now;
  ts_t         base_d [4];
  int unsigned items_queued;
  int unsigned burst_max;
  int unsigned gap_max;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_stall_e   rx_stall;
  logic        hold_req;
  logic        hold_taken;
  int unsigned hold_left;
  logic [2:0]  stall_tick;
  pulse_word_t drv_word;
  sweep_word_t drv_pred;
  sweep_word_t mon_due;

  function automatic logic [32:0] bin_edge(input int unsigned i);
    return {23'd0, cfg_bias} + {22'd0, Bounds[i]};
  endfunction

  function automatic bit classify_width(input ts_t width, output kind_e kind, output logic ax);
    logic [32:0] w;
    w = {1'b0, width};
    kind = KindLaser;
    ax = AxisAz;
    classify_width = 1'b0;
    if (w > bin_edge(0) && w < bin_edge(1)) begin
      classify_width = 1'b1;
    end else begin
      for (int i = 1; i < NumBounds - 1; i++) begin
        if (!classify_width && (w > bin_edge(i) || (i != 1 && w == bin_edge(i)))
            && w < bin_edge(i + 1)) begin
          // bins 1 to 4 are sync, 5 to 8 skip sync, alternating axes
          kind = (i < 5) ? KindSync : KindSkip;
          ax = ~i[0];
          classify_width = 1'b1;
        end
      end
    end
  endfunction

  function automatic bit track_axis(input logic ax, input kind_e kind, input logic pax,
                                    input ts_t rise, output sweep_word_t res);
    phase_e     ph;
    phase_e     nxt;
    logic [1:0] ia;
    logic [1:0] ib;
    logic [1:0] slot;
    bit         mine_sync;
    bit         mine_skip;
    ts_t        delta;
    longint     gap;
    track_axis = 1'b0;
    res = '0;
    ph = trk_phase[ax];
    nxt = PhSearch;
    ia = {ax, StationA};
    ib = {ax, StationB};
    mine_sync = (kind == KindSync) && (pax == ax);
    mine_skip = (kind == KindSkip) && (pax == ax);
    if (ph == PhSkipB) begin
      if (mine_sync) begin
        sync_st[ib] = rise;
        nxt = PhWaitB;
      end else if (mine_skip) begin
        nxt = PhSkipB;
      end
    end else if (mine_sync) begin
      sync_st[ia] = rise;
      nxt = PhSyncA;
    end else if (mine_skip) begin
      nxt = (ph == PhSyncA) ? PhWaitA : PhSkipB;
    end else if (kind == KindLaser && (ph == PhWaitA || ph == PhWaitB)) begin
      slot = (ph == PhWaitA) ? ia : ib;
      delta = rise - sync_st[slot];
      gap = longint'($signed(delta)) - longint'($signed(prev_d[slot]));
      if (gap < 0) gap = -gap;
      if (prev_d[slot] != '0 && gap < longint'(cfg_maxd)) begin
        res.sync_ts = sync_st[slot];
        res.laser_ts = rise;
        res.station = slot[0];
        res.axis = ax;
        track_axis = 1'b1;
      end
      prev_d[slot] = delta;
    end
    trk_phase[ax] = nxt;
  endfunction

  function automatic bit decode_pulse(input ts_t rise, input ts_t fall,
                                      output sweep_word_t res);
    kind_e       kind;
    logic        pax;
    sweep_word_t az_res;
    sweep_word_t el_res;
    bit          az_hit;
    bit          el_hit;
    decode_pulse = 1'b0;
    res = '0;
    if (classify_width(fall - rise, kind, pax)) begin
      az_hit = track_axis(AxisAz, kind, pax, rise, az_res);
      el_hit = track_axis(AxisEl, kind, pax, rise, el_res);
      if (az_hit) res = az_res;
      else if (el_hit) res = el_res;
      decode_pulse = az_hit || el_hit;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic ts_t next_time();
    t_now += $urandom_range(3000, 8000);
    return t_now;
  endfunction

  function automatic ts_t pick_width(input kind_e kind, input logic ax);
    int unsigned bin;
    if (kind == KindLaser) bin = 0;
    else bin = ((kind == KindSync) ? 1 : 5) + ax + 2 * $urandom_range(0, 1);
    // the lower edge of the two lowest bins is exclusive
    pick_width = cfg_bias + $urandom_range(Bounds[bin] + (bin < 2), Bounds[bin + 1] - 1);
  endfunction

  task automatic queue_raw(input ts_t rise, input ts_t fall);
    pulse_word_t pw;
    pw.rise = rise;
    pw.fall = fall;
    pulses_pending.push_back(pw);
    items_queued++;
  endtask

  task automatic queue_kind(input kind_e kind, input logic ax, input ts_t rise);
    queue_raw(rise, rise + pick_width(kind, ax));
  endtask

  task automatic queue_sweep(input logic ax, input sweep_form_e form, input bit steady);
    ts_t        sync_rise;
    ts_t        rise;
    ts_t        delta;
    logic [1:0] slot;
    int         span;
    int         jit;
    slot = {ax, (form == FormB || form == FormBLong) ? StationB : StationA};
    if (form != FormA) queue_kind(KindSkip, ax, next_time());
    if (form == FormBLong) queue_kind(KindSkip, ax, next_time());
    if (form == FormQuirk) queue_kind(KindSync, ax, next_time());
    sync_rise = next_time();
    queue_kind(KindSync, ax, sync_rise);
    if (form == FormA || form == FormQuirk) queue_kind(KindSkip, ax, next_time());
    span = int'(cfg_maxd);
    if (base_d[slot] == '0 || (!steady && $urandom_range(0, 9) == 0)) begin
      case ($urandom_range(0, 3))
        0:       base_d[slot] = 32'h7FFF_FFFF - $urandom_range(0, 2 * span);
        1:       base_d[slot] = $urandom;
        default: base_d[slot] = $urandom_range(20000, 400000);
      endcase
    end
    jit = 0;
    if (!steady) begin
      case ($urandom_range(0, 5))
        0:       jit = span;
        1:       jit = -span;
        2:       jit = span - 1;
        3:       jit = 1 - span;
        default: jit = int'($urandom_range(0, 2 * span)) - span;
      endcase
    end
    delta = base_d[slot] + ts_t'(jit);
    rise = sync_rise + delta;
    queue_kind(KindLaser, ax, rise);
    base_d[slot] = delta;
    t_now = rise;
  endtask

  task automatic queue_broken();
    ts_t         t;
    int unsigned r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 3);
      t = next_time();
      if (r == 3) begin
        case ($urandom_range(0, 3))
          0:       queue_raw(t, t + ts_t'(bin_edge(0)));
          1:       queue_raw(t, t + ts_t'(bin_edge(1)));
          2:       queue_raw(t, t + ts_t'(bin_edge(NumBounds - 1)) + $urandom_range(0, 5000));
          default: queue_raw(t, t + $urandom_range(0, ts_t'(bin_edge(0))));
        endcase
      end else begin
        queue_kind(kind_e'(r), 1'($urandom_range(0, 1)), t);
      end
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned target;
    int unsigned r;
    target = items_queued + count;
    while (items_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_sweep(1'($urandom_range(0, 1)),
                              sweep_form_e'($urandom_range(0, 3)), 1'b0);
      else if (r < 85) queue_broken();
      else queue_raw($urandom, $urandom);
    end
  endtask

  task automatic queue_directed();
    ts_t t;
    for (int i = 0; i < NumBounds; i++) begin
      t = next_time();
      queue_raw(t, t + Bounds[i]);
    end
    t = next_time();
    queue_raw(t, t + Bounds[0] + 1);
    t = next_time();
    queue_raw(t, t + Bounds[1] - 1);
    t = next_time();
    queue_raw(t, t + Bounds[1] + 1);
    t = next_time();
    queue_raw(t, t + Bounds[NumBounds - 1] - 1);
    t = next_time();
    queue_raw(t, t);
    t = next_time();
    queue_raw(t, t - 1);
    repeat (2) queue_sweep(AxisAz, FormA, 1'b1);
    repeat (2) queue_sweep(AxisEl, FormB, 1'b1);
  endtask

  task automatic wait_drained();
    while (pulses_pending.size() != 0 || pulse_if.valid || sweeps_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [BiasBits-1:0] bias, input logic [MaxBits-1:0] maxd);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgWidthBias;
    cfg_data_i <= {{(CfgDataBits - BiasBits){1'b0}}, bias};
    @(posedge clk_i);
    cfg_idx_i <= CfgMaxDelta;
    cfg_data_i <= maxd;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_bias = bias;
    cfg_maxd = maxd;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("== FAIL ==");
    $finish;
  end

  // sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pulse_if.valid <= 1'b0;
    end else begin
      if (pulse_if.valid && pulse_if.ready) begin
        if (decode_pulse(pulse_if.rise_time, pulse_if.fall_time, drv_pred))
          sweeps_due.push_back(drv_pred);
      end
      if (!pulse_if.valid || pulse_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          pulse_if.valid <= 1'b0;
        end else if (pulses_pending.size() != 0) begin
          drv_word = pulses_pending.pop_front();
          pulse_if.valid <= 1'b1;
          pulse_if.rise_time <= drv_word.rise;
          pulse_if.fall_time <= drv_word.fall;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, burst_max);
            gap_left <= $urandom_range(0, gap_max);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          pulse_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 3'd1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      sweep_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left <= HoldCycles;
      hold_taken <= 1'b1;
      sweep_if.ready <= 1'b0;
    end else begin
      case (rx_stall)
        StallNone:     sweep_if.ready <= 1'b1;
        StallRandom:   sweep_if.ready <= 1'($urandom_range(0, 1));
        StallPeriodic: sweep_if.ready <= (stall_tick < 3'd5);
        default:       sweep_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sweep_if.valid && sweep_if.ready) begin
      if (sweeps_due.size() == 0) begin
        report_mismatch($sformatf("unexpected sweep word, sync %h laser %h",
                                  sweep_if.sync_ts, sweep_if.laser_ts));
      end else begin
        mon_due = sweeps_due.pop_front();
        if (sweep_if.sync_ts !== mon_due.sync_ts)
          report_mismatch($sformatf("sync_ts %h, expected %h",
                                    sweep_if.sync_ts, mon_due.sync_ts));
        if (sweep_if.laser_ts !== mon_due.laser_ts)
          report_mismatch($sformatf("laser_ts %h, expected %h",
                                    sweep_if.laser_ts, mon_due.laser_ts));
        if (sweep_if.station !== mon_due.station)
          report_mismatch($sformatf("station %b, expected %b",
                                    sweep_if.station, mon_due.station));
        if (sweep_if.axis !== mon_due.axis)
          report_mismatch($sformatf("axis %b, expected %b", sweep_if.axis, mon_due.axis));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgWidthBias;
    cfg_data_i = '0;
    pulse_if.valid = 1'b0;
    pulse_if.rise_time = '0;
    pulse_if.fall_time = '0;
    sweep_if.ready = 1'b0;
    cfg_bias = WidthBiasRst;
    cfg_maxd = MaxDeltaRst;
    for (int i = 0; i < NumAxes; i++) trk_phase[i] = PhSearch;
    for (int i = 0; i < 4; i++) begin
      sync_st[i] = '0;
      prev_d[i] = '0;
      base_d[i] = '0;
    end
    mismatches = 0;
    items_queued = 0;
    t_now = $urandom;
    burst_max = 4;
    gap_max = 3;
    burst_left = 0;
    gap_left = 0;
    rx_stall = StallRandom;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    stall_tick = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_directed();
    queue_random(150);

    reconfigure(10'd1023, 16'hFFFF);
    rx_stall = StallNone;
    burst_max = 1;
    gap_max = 0;
    queue_random(250);

    reconfigure(10'($urandom_range(0, 1023)), 16'($urandom_range(1000, 30000)));
    rx_stall = StallPeriodic;
    burst_max = 6;
    gap_max = 8;
    queue_random(125);
    wait_drained();
    queue_random(125);

    reconfigure('0, '0);
    rx_stall = StallHeavy;
    burst_max = 3;
    gap_max = 2;
    queue_random(100);

    reconfigure(10'($urandom_range(0, 1023)), 16'd1);
    rx_stall = StallRandom;
    burst_max = 5;
    gap_max = 4;
    queue_random(150);

    reconfigure(10'($urandom_range(0, 1023)), 16'($urandom_range(100, 65535)));
    burst_max = 8;
    gap_max = 1;
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(negedge clk_i);
    queue_random(300);

    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
